[hdl/i2c_master_byte_transfer_core_defines.svh]
// Assertion macros shared by the I2C byte transfer core.
// Each macro checks one implication on the rising clock edge, disabled in reset.
`ifndef I2C_MASTER_BYTE_TRANSFER_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_TRANSFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define I2CMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cmb: same-cycle check failed");
// Next-cycle implication.
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmb: next-cycle check failed");
`else
`define I2CMB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/i2cmb_pkg.sv]
package i2cmb_pkg;

    // Request kinds carried by an input item.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;

    // Fields of one input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] device_address;
        logic [7:0] write_data;
        logic       scl_in;
        logic       sda_in;
    } request_t;

    // Fields of one result item.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_data;
    } result_t;

endpackage

[hdl/i2cmb_in_if.sv]
// Input channel: one item per bus tick.
interface i2cmb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] device_address;
    logic [7:0] write_data;
    logic       scl_in;
    logic       sda_in;

    modport source (output valid, kind, device_address, write_data, scl_in, sda_in,
                    input ready);
    modport sink (input valid, kind, device_address, write_data, scl_in, sda_in,
                  output ready);
endinterface

[hdl/i2cmb_out_if.sv]
// Output channel: one result item per accepted input item.
interface i2cmb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;

    modport source (output valid, scl_release, sda_release, busy_res, done_res, ack_ok,
                    read_data, input ready);
    modport sink (input valid, scl_release, sda_release, busy_res, done_res, ack_ok,
                  read_data, output ready);
endinterface

[hdl/i2cmb_engine.sv]
`include "i2c_master_byte_transfer_core_defines.svh"

module i2cmb_engine
    import i2cmb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  request_t        req,
    input  logic [15:0]     phase_ticks,
    output result_t         res_next
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TXACK_LOW,
        PH_TXACK_HIGH,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_NACK_LOW,
        PH_NACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_HIGH,
        PH_STOP_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] tick_counter_reg, tick_counter_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        read_mode_reg, read_mode_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic [7:0]  pending_data_reg, pending_data_next;
    logic        on_data_byte_reg, on_data_byte_next;

    logic [15:0] limit;
    logic        releases_scl;
    logic        stretched;
    logic        last_tick;
    logic        phase_end;
    logic        done;
    logic        start_req;

    // Phase timing: a zero length counts as one tick, and a phase that
    // releases SCL holds while a slave keeps the line low.
    assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign releases_scl = (phase_reg == PH_TX_HIGH) || (phase_reg == PH_TXACK_HIGH) ||
                          (phase_reg == PH_RX_HIGH) || (phase_reg == PH_NACK_HIGH) ||
                          (phase_reg == PH_STOP_HIGH);
    assign stretched = releases_scl && !req.scl_in;
    assign last_tick = ({1'b0, tick_counter_reg} + 17'd1) >= {1'b0, limit};
    assign phase_end = (phase_reg != PH_IDLE) && !stretched && last_tick;
    assign start_req = (phase_reg == PH_IDLE) &&
                       ((req.kind == KIND_WRITE) || (req.kind == KIND_READ));

    // Next state for one bus tick.
    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        tick_counter_next = tick_counter_reg;
        ack_flag_next     = ack_flag_reg;
        read_mode_next    = read_mode_reg;
        held_data_next    = held_data_reg;
        pending_data_next = pending_data_reg;
        on_data_byte_next = on_data_byte_reg;
        done              = 1'b0;

        if (start_req)
        begin
            read_mode_next    = (req.kind == KIND_READ);
            shift_byte_next   = {req.device_address[7:1],
                                 req.device_address[0] | (req.kind == KIND_READ)};
            pending_data_next = req.write_data;
            on_data_byte_next = 1'b0;
            bit_index_next    = 4'd0;
            tick_counter_next = 16'd0;
            phase_next        = PH_START;
        end
        else if (phase_reg != PH_IDLE && !stretched)
        begin
            tick_counter_next = last_tick ? 16'd0 : tick_counter_reg + 16'd1;
        end

        if (phase_end)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_START:
                begin
                    bit_index_next = 4'd0;
                    phase_next     = PH_TX_LOW;
                end
                PH_TX_LOW:
                begin
                    phase_next = PH_TX_HIGH;
                end
                PH_TX_HIGH:
                begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    bit_index_next  = bit_index_reg + 4'd1;
                    phase_next      = (bit_index_next >= BITS_PER_BYTE) ? PH_TXACK_LOW
                                                                         : PH_TX_LOW;
                end
                PH_TXACK_LOW:
                begin
                    phase_next = PH_TXACK_HIGH;
                end
                PH_TXACK_HIGH:
                begin
                    // An acknowledge is SDA pulled low by the slave.
                    ack_flag_next  = !req.sda_in;
                    bit_index_next = 4'd0;
                    if (read_mode_reg)
                    begin
                        shift_byte_next = 8'd0;
                        phase_next      = PH_RX_LOW;
                    end
                    else if (!on_data_byte_reg)
                    begin
                        on_data_byte_next = 1'b1;
                        shift_byte_next   = pending_data_reg;
                        phase_next        = PH_TX_LOW;
                    end
                    else
                    begin
                        phase_next = PH_STOP_LOW;
                    end
                end
                PH_RX_LOW:
                begin
                    phase_next = PH_RX_HIGH;
                end
                PH_RX_HIGH:
                begin
                    shift_byte_next = {shift_byte_reg[6:0], req.sda_in};
                    bit_index_next  = bit_index_reg + 4'd1;
                    if (bit_index_next >= BITS_PER_BYTE)
                    begin
                        held_data_next = shift_byte_next;
                        phase_next     = PH_NACK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_NACK_LOW:
                begin
                    phase_next = PH_NACK_HIGH;
                end
                PH_NACK_HIGH:
                begin
                    phase_next = PH_STOP_LOW;
                end
                PH_STOP_LOW:
                begin
                    phase_next = PH_STOP_HIGH;
                end
                PH_STOP_HIGH:
                begin
                    phase_next = PH_STOP_END;
                end
                PH_STOP_END:
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Line levels and status as they stand after the tick.
    always_comb
    begin
        res_next.scl_release = 1'b1;
        res_next.sda_release = 1'b1;
        unique case (phase_next)
            PH_START:
            begin
                res_next.sda_release = 1'b0;
            end
            PH_TX_LOW:
            begin
                res_next.scl_release = 1'b0;
                res_next.sda_release = shift_byte_next[7];
            end
            PH_TX_HIGH:
            begin
                res_next.sda_release = shift_byte_next[7];
            end
            PH_TXACK_LOW, PH_RX_LOW, PH_NACK_LOW:
            begin
                res_next.scl_release = 1'b0;
            end
            PH_STOP_LOW:
            begin
                res_next.scl_release = 1'b0;
                res_next.sda_release = 1'b0;
            end
            PH_STOP_HIGH:
            begin
                res_next.sda_release = 1'b0;
            end
            default:
            begin
            end
        endcase
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.ack_ok    = ack_flag_next;
        res_next.read_data = held_data_next;
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= 4'd0;
            shift_byte_reg   <= 8'd0;
            tick_counter_reg <= 16'd0;
            ack_flag_reg     <= 1'b0;
            read_mode_reg    <= 1'b0;
            held_data_reg    <= 8'd0;
            pending_data_reg <= 8'd0;
            on_data_byte_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            tick_counter_reg <= tick_counter_next;
            ack_flag_reg     <= ack_flag_next;
            read_mode_reg    <= read_mode_next;
            held_data_reg    <= held_data_next;
            pending_data_reg <= pending_data_next;
            on_data_byte_reg <= on_data_byte_next;
        end
    end

    // The counter is cleared whenever the bus rests.
    `I2CMB_ASSERT_IMP(a_idle_counter_clear, clk, rst_n, phase_reg == PH_IDLE, tick_counter_reg == 16'd0)
    // The bit counter never runs past one byte.
    `I2CMB_ASSERT_IMP(a_bit_index_range, clk, rst_n, 1'b1, bit_index_reg <= BITS_PER_BYTE)
    // A request taken while idle always opens with a start condition.
    `I2CMB_ASSERT_NEXT(a_start_follows_request, clk, rst_n, step && start_req, phase_reg == PH_START)

endmodule

[hdl/i2c_master_byte_transfer_core.sv]
// I2C master for one single-byte write or read. Each input item is one tick of the
// bus machine: it carries the sampled SCL/SDA levels and, while the core is idle,
// an optional write or read request. Every accepted item yields exactly one result
// item showing the open-drain line controls and status after that tick, delivered
// in the next cycle from an output register. The core takes one item per clock;
// the input stalls only while a result sits unclaimed in the output
// register and the sink is not ready. Each bus machine phase lasts cfg_write_data
// ticks as last written (reset 4, zero acts as one), and phases that release SCL
// wait while a slave holds it low.
`include "i2c_master_byte_transfer_core_defines.svh"

module i2c_master_byte_transfer_core
    import i2cmb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [15:0]   cfg_write_data,
    i2cmb_in_if.sink      req,
    i2cmb_out_if.source   res
);

    logic [15:0] phase_ticks_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    request_t    req_item;
    logic        step;

    // Phase length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_write_en)
        begin
            phase_ticks_reg <= cfg_write_data;
        end
    end

    // Input handshake: take an item whenever the output register is free or drains.
    assign req.ready = !out_valid_reg || res.ready;
    assign step      = req.valid && req.ready;

    assign req_item.kind           = req.kind;
    assign req_item.device_address = req.device_address;
    assign req_item.write_data     = req.write_data;
    assign req_item.scl_in         = req.scl_in;
    assign req_item.sda_in         = req.sda_in;

    i2cmb_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .req         (req_item),
        .phase_ticks (phase_ticks_reg),
        .res_next    (result_next)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_release = result_reg.scl_release;
    assign res.sda_release = result_reg.sda_release;
    assign res.busy_res    = result_reg.busy_res;
    assign res.done_res    = result_reg.done_res;
    assign res.ack_ok      = result_reg.ack_ok;
    assign res.read_data   = result_reg.read_data;

    // Every accepted item produces a result in the next cycle.
    `I2CMB_ASSERT_NEXT(a_result_after_accept, clk, rst_n, step, out_valid_reg)
    // A finished transfer is never reported as still busy.
    `I2CMB_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_valid_reg && result_reg.done_res, !result_reg.busy_res)
    // A pending unclaimed result blocks the input.
    `I2CMB_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_valid_reg && !res.ready, !req.ready)

endmodule
